[design/stt_pkg.sv]
// ---------------------------------------------------------------------------
// stt_pkg: shared types and constants for the source text tokenizer
// Mode codes, tag values, record kinds, error codes and the keyword table.
// ---------------------------------------------------------------------------
package stt_pkg;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_IDENT   = 4'd1,
        M_NUMBER  = 4'd2,
        M_STRING  = 4'd3,
        M_ESCAPE  = 4'd4,
        M_COMMENT = 4'd5,
        M_PENDING = 4'd6,
        M_ERROR   = 4'd7
    } mode_t;

    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_TOKEN = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_CHAR    = 2'd0;
    localparam logic [1:0] ERR_STR_END = 2'd1;
    localparam logic [1:0] ERR_ESC_END = 2'd2;
    localparam logic [1:0] ERR_BAD_ESC = 2'd3;

    localparam logic [6:0] TAG_IDENT  = 7'd44;
    localparam logic [6:0] TAG_NUMBER = 7'd45;
    localparam logic [6:0] TAG_STRING = 7'd46;
    localparam logic [6:0] TAG_PAIR0  = 7'd47;
    localparam logic [6:0] TAG_SHL    = 7'd59;
    localparam logic [6:0] TAG_SHR    = 7'd60;
    localparam logic [6:0] TAG_SINGLE0 = 7'd61;
    localparam logic [6:0] TAG_END    = 7'd81;

    localparam int          TABLE_SIZE = 44;
    localparam logic [19:0] POS_MAX = 20'hFFFFF;
    localparam logic [62:0] NUM_MAX = {63{1'b1}};
    // largest acc for which acc*10+9 fits
    localparam logic [62:0] NUM_SAFE = 63'd922337203685477579;

    typedef struct packed {
        logic [1:0]  rec_kind;
        logic [6:0]  tag;
        logic [19:0] line;
        logic [19:0] col;
        logic [7:0]  text_byte;
        logic [62:0] number_value;
        logic [1:0]  error_code;
        logic        last;
    } rec_t;

    // one queue entry: up to two records caused by one byte
    typedef struct packed {
        logic [1:0] cnt;
        rec_t       r0;
        rec_t       r1;
    } entry_t;

    // keyword text, byte p of entry i (0 past end)
    function automatic logic [7:0] kw_char(input int i, input int p);
        string s;
        case (i)
            0: s = "rax";   1: s = "rbx";   2: s = "rcx";   3: s = "rdx";
            4: s = "rsi";   5: s = "rdi";   6: s = "rbp";   7: s = "r8";
            8: s = "r9";    9: s = "r10";   10: s = "r11";  11: s = "r12";
            12: s = "r13";  13: s = "r14";  14: s = "r15";  15: s = "xmm0";
            16: s = "xmm1"; 17: s = "xmm2"; 18: s = "xmm3"; 19: s = "xmm4";
            20: s = "xmm5"; 21: s = "xmm6"; 22: s = "xmm7"; 23: s = "xmm8";
            24: s = "xmm9"; 25: s = "xmm10"; 26: s = "xmm11"; 27: s = "xmm12";
            28: s = "xmm13"; 29: s = "xmm14"; 30: s = "xmm15"; 31: s = "branch";
            32: s = "break"; 33: s = "continue"; 34: s = "else"; 35: s = "if";
            36: s = "loop"; 37: s = "macro"; 38: s = "pop"; 39: s = "proc";
            40: s = "push"; 41: s = "return"; 42: s = "val"; 43: s = "var";
            default: s = "";
        endcase
        if (p < s.len()) return s[p];
        return 8'd0;
    endfunction

    function automatic logic [3:0] kw_len(input int i);
        logic [3:0] n;
        n = 4'd0;
        for (int p = 0; p < 8; p++) begin
            if (kw_char(i, p) != 8'd0) n = 4'(p + 1);
        end
        return n;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h09 || c == 8'h0D || c == 8'h0A || c == 8'h20;
    endfunction

    function automatic logic starts_pair(input logic [7:0] c);
        case (c)
            "+", "-", "*", "/", "%", "&", "|", "^", "<", ">", "=", "!": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // 0..19 index of a single-char op, 31 if none
    function automatic logic [4:0] single_idx(input logic [7:0] c);
        case (c)
            "[": return 5'd0;  "]": return 5'd1;  "(": return 5'd2;  ")": return 5'd3;
            "{": return 5'd4;  "}": return 5'd5;  "+": return 5'd6;  "-": return 5'd7;
            "*": return 5'd8;  "/": return 5'd9;  "%": return 5'd10; "&": return 5'd11;
            "|": return 5'd12; "^": return 5'd13; "=": return 5'd14; "<": return 5'd15;
            ">": return 5'd16; "#": return 5'd17; ",": return 5'd18; ";": return 5'd19;
            default: return 5'd31;
        endcase
    endfunction

    function automatic logic [3:0] eq_idx(input logic [7:0] c);
        case (c)
            "+": return 4'd0;  "-": return 4'd1;  "*": return 4'd2;  "/": return 4'd3;
            "%": return 4'd4;  "&": return 4'd5;  "|": return 4'd6;  "^": return 4'd7;
            "<": return 4'd8;  ">": return 4'd9;  "=": return 4'd10; "!": return 4'd11;
            default: return 4'd15;
        endcase
    endfunction

endpackage

[design/stt_front.sv]
// ---------------------------------------------------------------------------
// stt_front: lexer state machine
// Takes one byte per beat, updates the lexer state and produces the records
// caused by the byte as one queue entry.
// ---------------------------------------------------------------------------
module stt_front #(
    parameter int KEYWORD_TOTAL = 44
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_ch,
    output logic            ent_valid,
    output stt_pkg::entry_t ent,
    input  logic            q_full
);
    import stt_pkg::*;

    localparam int KW = (KEYWORD_TOTAL < TABLE_SIZE) ? KEYWORD_TOTAL : TABLE_SIZE;

    mode_t              mode_reg, mode_next;
    logic [7:0]         pend_reg, pend_next;
    logic [KW-1:0]      mask_reg, mask_next;
    logic [3:0]         len_reg, len_next;
    logic [62:0]        acc_reg, acc_next;
    logic [19:0]        tline_reg, tline_next, tcol_reg, tcol_next;
    logic [19:0]        cline_reg, cline_next, ccol_reg, ccol_next;

    logic       fire;
    logic       ended;
    logic [1:0] n;
    rec_t       r [2];
    logic [6:0] kw_tag;
    logic       fresh;
    logic [4:0] si;
    logic [3:0] ei;
    logic [62:0] acc10;

    assign in_ready  = !q_full;
    assign fire      = in_valid && in_ready;
    assign ent_valid = fire && (n != 2'd0);

    always_comb begin
        kw_tag = TAG_IDENT;
        for (int i = KW - 1; i >= 0; i--) begin
            if (mask_reg[i] && kw_len(i) == len_reg) kw_tag = 7'(i);
        end
    end

    assign acc10 = (acc_reg << 3) + (acc_reg << 1) + 63'(in_ch - 8'd48);

    always_comb begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        mask_next  = mask_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        ended      = 1'b0;
        n          = 2'd0;
        fresh      = 1'b0;
        si         = single_idx(in_ch);
        ei         = eq_idx(pend_reg);
        for (int k = 0; k < 2; k++) begin
            r[k] = '0;
        end

        case (mode_reg)
            M_IDENT: begin
                if (is_alpha(in_ch) || is_digit(in_ch)) begin
                    for (int i = 0; i < KW; i++) begin
                        if (len_reg >= kw_len(i) || kw_char(i, int'(len_reg)) != in_ch)
                            mask_next[i] = 1'b0;
                    end
                    if (len_reg < 4'd15) len_next = len_reg + 4'd1;
                    r[0] = '{KIND_TEXT, TAG_IDENT, tline_reg, tcol_reg, in_ch,
                             63'd0, 2'd0, 1'b0};
                    n = 2'd1;
                end else begin
                    r[0] = '{KIND_TOKEN, kw_tag, tline_reg, tcol_reg, 8'd0,
                             63'd0, 2'd0, 1'b0};
                    n = 2'd1;
                    fresh = 1'b1;
                end
            end
            M_NUMBER: begin
                if (is_digit(in_ch)) begin
                    if (acc_reg > NUM_SAFE && (acc_reg > NUM_SAFE + 63'd1 ||
                            in_ch > "7")) acc_next = NUM_MAX;
                    else acc_next = acc10;
                end else begin
                    r[0] = '{KIND_TOKEN, TAG_NUMBER, tline_reg, tcol_reg, 8'd0,
                             acc_reg, 2'd0, 1'b0};
                    n = 2'd1;
                    fresh = 1'b1;
                end
            end
            M_STRING: begin
                if (in_ch == 8'd0) begin
                    r[0] = '{KIND_ERROR, 7'd0, cline_reg, ccol_reg, 8'd0, 63'd0,
                             ERR_STR_END, 1'b0};
                    n = 2'd1;
                    mode_next = M_IDLE;
                    ended = 1'b1;
                end else if (in_ch == "\"") begin
                    r[0] = '{KIND_TOKEN, TAG_STRING, tline_reg, tcol_reg, 8'd0,
                             63'd0, 2'd0, 1'b0};
                    n = 2'd1;
                    mode_next = M_IDLE;
                end else if (in_ch == "\\") begin
                    mode_next = M_ESCAPE;
                end else begin
                    r[0] = '{KIND_TEXT, TAG_STRING, tline_reg, tcol_reg, in_ch,
                             63'd0, 2'd0, 1'b0};
                    n = 2'd1;
                end
            end
            M_ESCAPE: begin
                n = 2'd1;
                mode_next = M_STRING;
                r[0] = '{KIND_TEXT, TAG_STRING, tline_reg, tcol_reg, 8'd0,
                         63'd0, 2'd0, 1'b0};
                case (in_ch)
                    8'd0: begin
                        r[0] = '{KIND_ERROR, 7'd0, cline_reg, ccol_reg, 8'd0,
                                 63'd0, ERR_ESC_END, 1'b0};
                        mode_next = M_IDLE;
                        ended = 1'b1;
                    end
                    "\\": r[0].text_byte = 8'h5C;
                    "0":  r[0].text_byte = 8'h00;
                    "r":  r[0].text_byte = 8'h0D;
                    "n":  r[0].text_byte = 8'h0A;
                    "t":  r[0].text_byte = 8'h09;
                    default: begin
                        r[0] = '{KIND_ERROR, 7'd0, cline_reg, ccol_reg, 8'd0,
                                 63'd0, ERR_BAD_ESC, 1'b0};
                        mode_next = M_ERROR;
                    end
                endcase
            end
            M_COMMENT: begin
                if (in_ch == 8'd0) fresh = 1'b1;
                else if (in_ch == 8'h0A) mode_next = M_IDLE;
            end
            M_PENDING: begin
                if (pend_reg == "/" && in_ch == "/") begin
                    mode_next = M_COMMENT;
                end else if (in_ch == "=" && ei != 4'd15) begin
                    r[0] = '{KIND_TOKEN, TAG_PAIR0 + 7'(ei), tline_reg, tcol_reg,
                             8'd0, 63'd0, 2'd0, 1'b0};
                    n = 2'd1;
                    mode_next = M_IDLE;
                end else if (pend_reg == in_ch && (in_ch == "<" || in_ch == ">")) begin
                    r[0] = '{KIND_TOKEN, (in_ch == "<") ? TAG_SHL : TAG_SHR,
                             tline_reg, tcol_reg, 8'd0, 63'd0, 2'd0, 1'b0};
                    n = 2'd1;
                    mode_next = M_IDLE;
                end else if (single_idx(pend_reg) == 5'd31) begin
                    // lone '!'
                    r[0] = '{KIND_ERROR, 7'd0, tline_reg, tcol_reg, 8'd0, 63'd0,
                             ERR_CHAR, 1'b0};
                    n = 2'd1;
                    if (in_ch == 8'd0) begin
                        mode_next = M_IDLE;
                        ended = 1'b1;
                    end else mode_next = M_ERROR;
                end else begin
                    r[0] = '{KIND_TOKEN, TAG_SINGLE0 + 7'(single_idx(pend_reg)),
                             tline_reg, tcol_reg, 8'd0, 63'd0, 2'd0, 1'b0};
                    n = 2'd1;
                    fresh = 1'b1;
                end
            end
            M_ERROR: begin
                if (in_ch == 8'd0) begin
                    mode_next = M_IDLE;
                    ended = 1'b1;
                end
            end
            default: fresh = 1'b1;
        endcase

        if (fresh) begin
            mode_next = M_IDLE;
            if (in_ch == 8'd0) begin
                r[n[0]] = '{KIND_TOKEN, TAG_END, cline_reg, ccol_reg, 8'd0, 63'd0,
                            2'd0, 1'b0};
                n = n + 2'd1;
                ended = 1'b1;
            end else if (is_space(in_ch)) begin
            end else if (is_alpha(in_ch)) begin
                tline_next = cline_reg;
                tcol_next  = ccol_reg;
                mode_next  = M_IDENT;
                len_next   = 4'd1;
                for (int i = 0; i < KW; i++) begin
                    mask_next[i] = (kw_char(i, 0) == in_ch);
                end
                r[n[0]] = '{KIND_TEXT, TAG_IDENT, cline_reg, ccol_reg, in_ch,
                            63'd0, 2'd0, 1'b0};
                n = n + 2'd1;
            end else if (is_digit(in_ch)) begin
                tline_next = cline_reg;
                tcol_next  = ccol_reg;
                acc_next   = 63'(in_ch - 8'd48);
                mode_next  = M_NUMBER;
            end else if (in_ch == "\"") begin
                tline_next = cline_reg;
                tcol_next  = ccol_reg;
                mode_next  = M_STRING;
            end else if (starts_pair(in_ch)) begin
                tline_next = cline_reg;
                tcol_next  = ccol_reg;
                pend_next  = in_ch;
                mode_next  = M_PENDING;
            end else if (si != 5'd31) begin
                r[n[0]] = '{KIND_TOKEN, TAG_SINGLE0 + 7'(si), cline_reg, ccol_reg,
                            8'd0, 63'd0, 2'd0, 1'b0};
                n = n + 2'd1;
            end else begin
                r[n[0]] = '{KIND_ERROR, 7'd0, cline_reg, ccol_reg, 8'd0, 63'd0,
                            ERR_CHAR, 1'b0};
                n = n + 2'd1;
                mode_next = M_ERROR;
            end
        end

        if (n == 2'd2) r[1].last = 1'b1;
        else r[0].last = 1'b1;

        if (ended) begin
            cline_next = 20'd1;
            ccol_next  = 20'd1;
        end else if (in_ch == 8'h0A) begin
            cline_next = (cline_reg < POS_MAX) ? cline_reg + 20'd1 : cline_reg;
            ccol_next  = 20'd1;
        end else begin
            cline_next = cline_reg;
            ccol_next  = (ccol_reg < POS_MAX) ? ccol_reg + 20'd1 : ccol_reg;
        end
    end

    assign ent.cnt = n;
    assign ent.r0  = r[0];
    assign ent.r1  = r[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            pend_reg  <= 8'd0;
            mask_reg  <= '1;
            len_reg   <= 4'd0;
            acc_reg   <= 63'd0;
            tline_reg <= 20'd1;
            tcol_reg  <= 20'd1;
            cline_reg <= 20'd1;
            ccol_reg  <= 20'd1;
        end else if (fire) begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            mask_reg  <= mask_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
            cline_reg <= cline_next;
            ccol_reg  <= ccol_next;
        end
    end

endmodule

[design/stt_queue.sv]
// ---------------------------------------------------------------------------
// stt_queue: entry queue between lexer and record output
// Four-deep FIFO of entries; full is registered state so the lexer ready
// does not depend on the output side combinationally.
// ---------------------------------------------------------------------------
module stt_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  stt_pkg::entry_t wr_data,
    output logic            full,
    output logic            rd_valid,
    output stt_pkg::entry_t rd_data,
    input  logic            rd_en
);
    import stt_pkg::*;

    entry_t     mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full     = cnt_reg == 3'd4;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 2'd1;
            if (rd_en) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, wr_en} - {2'd0, rd_en};
        end
    end

endmodule

[design/stt_back.sv]
// ---------------------------------------------------------------------------
// stt_back: record serializer
// Hands out the one or two records of each queue entry as single beats.
// ---------------------------------------------------------------------------
module stt_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  stt_pkg::entry_t q_data,
    output logic            q_pop,
    output logic            out_valid,
    output stt_pkg::rec_t   out_rec,
    input  logic            out_ready
);
    import stt_pkg::*;

    logic sel_reg;

    assign out_valid = q_valid;
    assign out_rec   = sel_reg ? q_data.r1 : q_data.r0;
    assign q_pop     = q_valid && out_ready && (sel_reg || q_data.cnt == 2'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
        end else if (q_valid && out_ready) begin
            sel_reg <= !q_pop;
        end
    end

endmodule

[design/source_text_tokenizer.sv]
// ---------------------------------------------------------------------------
// source_text_tokenizer: streaming lexer for a small assembly-like language
//
// Input: one source byte per beat on s_ch (s_valid/s_ready); 0 ends a text.
// Output: records on m_* (m_valid/m_ready): text bytes, tokens, errors, with
// m_last on the final record caused by an input byte.
// Throughput: one byte per cycle while the queue is not full; a byte causing
// two records is handed out one record at a time, absorbed by a four-entry
// queue between lexer and output; records are registered in the queue first.
// The lexer step (mask update, times-ten accumulate) is combinational.
// When m_ready is low the queue fills and s_ready drops once it holds four
// entries. Reset returns the lexer to idle, line and column to 1 and
// empties the queue.
// ---------------------------------------------------------------------------
module source_text_tokenizer #(
    parameter int KEYWORD_TOTAL = 44
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_rec_kind,
    output logic [6:0]  m_tag,
    output logic [19:0] m_line,
    output logic [19:0] m_col,
    output logic [7:0]  m_text_byte,
    output logic [62:0] m_number_value,
    output logic [1:0]  m_error_code,
    output logic        m_last
);
    import stt_pkg::*;

    logic   ent_valid, q_full, q_valid, q_pop;
    entry_t ent, q_data;
    rec_t   rec;

    stt_front #(.KEYWORD_TOTAL(KEYWORD_TOTAL)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_ch(s_ch),
        .ent_valid(ent_valid), .ent(ent), .q_full(q_full)
    );

    stt_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(ent_valid), .wr_data(ent), .full(q_full),
        .rd_valid(q_valid), .rd_data(q_data), .rd_en(q_pop)
    );

    stt_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
        .out_valid(m_valid), .out_rec(rec), .out_ready(m_ready)
    );

    assign m_rec_kind     = rec.rec_kind;
    assign m_tag          = rec.tag;
    assign m_line         = rec.line;
    assign m_col          = rec.col;
    assign m_text_byte    = rec.text_byte;
    assign m_number_value = rec.number_value;
    assign m_error_code   = rec.error_code;
    assign m_last         = rec.last;

endmodule
